/* rtl/cfp_pkg.sv */
// Shared codes and types for the command frame parser: phases, result events, register address and result item.
`timescale 1ns / 1ps
package cfp_pkg;

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_LENGTH = 3'd1;
	localparam logic [2:0] PH_CMD    = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_FCS    = 3'd4;

	localparam logic [2:0] EV_IGNORED = 3'd0;
	localparam logic [2:0] EV_HEADER  = 3'd1;
	localparam logic [2:0] EV_PAYLOAD = 3'd2;
	localparam logic [2:0] EV_GOOD    = 3'd3;
	localparam logic [2:0] EV_BAD     = 3'd4;
	localparam logic [2:0] EV_ZEROLEN = 3'd5;

	localparam int unsigned ADDR_W = 3;
	localparam logic [0:0] REG_START_BYTE = 1'b0;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] command_id;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_length;
	} result_t;

endpackage

/* rtl/command_frame_parser_core.sv */
// Top level of the command frame parser: byte-wise frame hunting, checksum and result register.
// The result item of an accepted byte appears in the output register in the cycle after the byte is taken.
// Throughput: one byte per cycle while no result is held or the held one is being taken.
// The frame state update is a single pass of logic from the state registers and the input byte.
// Reset (arst_n low, asynchronous): hunting phase, state cleared, start_byte 0, no result.
`timescale 1ns / 1ps
module command_frame_parser_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 event_res,
	output logic [7:0]                 command_id,
	output logic [7:0]                 payload_byte,
	output logic [7:0]                 payload_index,
	output logic [7:0]                 frame_length,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cfp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import cfp_pkg::*;

	logic [7:0] start_byte_q;
	logic [2:0] phase_q, phase_d;
	logic [7:0] length_q, length_d;
	logic [7:0] command_q, command_d;
	logic [7:0] index_q, index_d;
	logic [7:0] xor_q, xor_d;
	logic       out_valid_q;
	result_t    res_d, res_q;
	logic       accept;
	logic       sel_start;

	assign pready    = 1'b1;
	assign sel_start = (paddr[ADDR_W-1] == REG_START_BYTE);
	assign prdata    = sel_start ? {24'd0, start_byte_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && sel_start) begin
			start_byte_q <= pwdata[7:0];
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_d   = PH_HUNT;
		length_d  = length_q;
		command_d = command_q;
		index_d   = index_q;
		xor_d     = xor_q;
		res_d     = '0;
		res_d.event_res = EV_IGNORED;
		case (phase_q)
			PH_LENGTH: begin
				length_d              = rx_byte;
				res_d.frame_length    = rx_byte;
				if (rx_byte == 8'd0) begin
					res_d.event_res = EV_ZEROLEN;
					phase_d         = PH_HUNT;
				end else begin
					res_d.event_res = EV_HEADER;
					xor_d           = rx_byte;
					phase_d         = PH_CMD;
				end
			end
			PH_CMD: begin
				command_d          = rx_byte;
				xor_d              = xor_q ^ rx_byte;
				res_d.event_res    = EV_HEADER;
				res_d.command_id   = rx_byte;
				res_d.frame_length = length_q;
				index_d            = 8'd0;
				phase_d            = (length_q == 8'd1) ? PH_FCS : PH_DATA;
			end
			PH_DATA: begin
				res_d.event_res     = EV_PAYLOAD;
				res_d.command_id    = command_q;
				res_d.frame_length  = length_q;
				res_d.payload_byte  = rx_byte;
				res_d.payload_index = index_q;
				xor_d               = xor_q ^ rx_byte;
				index_d             = index_q + 8'd1;
				phase_d             = (index_d == length_q - 8'd1) ? PH_FCS : PH_DATA;
			end
			PH_FCS: begin
				res_d.event_res    = (xor_q == rx_byte) ? EV_GOOD : EV_BAD;
				res_d.command_id   = command_q;
				res_d.frame_length = length_q;
				phase_d            = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == start_byte_q) begin
					res_d.event_res = EV_HEADER;
					length_d        = 8'd0;
					command_d       = 8'd0;
					index_d         = 8'd0;
					xor_d           = 8'd0;
					phase_d         = PH_LENGTH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			length_q    <= 8'd0;
			command_q   <= 8'd0;
			index_q     <= 8'd0;
			xor_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				length_q  <= length_d;
				command_q <= command_d;
				index_q   <= index_d;
				xor_q     <= xor_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = res_q.event_res;
	assign command_id    = res_q.command_id;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign frame_length  = res_q.frame_length;

endmodule

/* rtl/cfp_checker.sv */
// Port-level checks for the command frame parser and their bind to the top level.
`timescale 1ns / 1ps
module cfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_res,
	input logic [7:0] command_id,
	input logic [7:0] payload_byte,
	input logic [7:0] payload_index,
	input logic [7:0] frame_length
);
	import cfp_pkg::*;

	a_accept_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted byte produced no result item");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res)
			&& $stable(payload_byte) && $stable(frame_length))
		else $error("stalled result item changed");

	a_payload_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0
			&& payload_index == 8'd0)
		else $error("payload fields set outside a payload item");

	a_no_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_IGNORED || event_res == EV_ZEROLEN)
			|-> command_id == 8'd0)
		else $error("command id set before a frame has one");

endmodule

bind command_frame_parser_core cfp_checker u_cfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.event_res     (event_res),
	.command_id    (command_id),
	.payload_byte  (payload_byte),
	.payload_index (payload_index),
	.frame_length  (frame_length)
);

/* dv/tb.sv */
// Testbench for the command frame parser core: frame hunting, payload stream and checksum results.
`timescale 1ns / 1ps
module tb;
	import cfp_pkg::*;

	localparam logic [ADDR_W-1:0] START_BYTE_ADDR = ADDR_W'(4 * REG_START_BYTE);
	localparam int LIMIT_NS = 5_000_000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_ready;
	logic [2:0] event_res;
	logic [7:0] command_id;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] frame_length;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	command_frame_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.command_id(command_id),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_length(frame_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// parser state as the testbench tracks it
	logic [7:0] start_value;
	logic [2:0] frame_phase;
	logic [7:0] held_length;
	logic [7:0] held_command;
	logic [7:0] next_index;
	logic [7:0] check_acc;

	result_t events_due[$];
	int mismatches;
	int frame_items;
	int idle_pct;
	int stall_pct;
	int hold_left;

	always #6 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic result_t advance_frame(input logic [7:0] b);
		result_t r;
		r = '0;
		r.event_res = EV_IGNORED;
		case (frame_phase)
			PH_LENGTH: begin
				held_length = b;
				r.frame_length = b;
				if (b == 8'd0) begin
					r.event_res = EV_ZEROLEN;
					frame_phase = PH_HUNT;
				end else begin
					r.event_res = EV_HEADER;
					check_acc = b;
					frame_phase = PH_CMD;
				end
			end
			PH_CMD: begin
				held_command = b;
				check_acc = check_acc ^ b;
				r.event_res = EV_HEADER;
				r.command_id = b;
				r.frame_length = held_length;
				next_index = 8'd0;
				frame_phase = (held_length == 8'd1) ? PH_FCS : PH_DATA;
			end
			PH_DATA: begin
				r.event_res = EV_PAYLOAD;
				r.command_id = held_command;
				r.frame_length = held_length;
				r.payload_byte = b;
				r.payload_index = next_index;
				check_acc = check_acc ^ b;
				next_index = next_index + 8'd1;
				if (next_index == held_length - 8'd1)
					frame_phase = PH_FCS;
			end
			PH_FCS: begin
				r.event_res = (check_acc == b) ? EV_GOOD : EV_BAD;
				r.command_id = held_command;
				r.frame_length = held_length;
				frame_phase = PH_HUNT;
			end
			default: begin
				frame_phase = PH_HUNT;
				if (b == start_value) begin
					r.event_res = EV_HEADER;
					held_length = 8'd0;
					held_command = 8'd0;
					next_index = 8'd0;
					check_acc = 8'd0;
					frame_phase = PH_LENGTH;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				$error("result item with none expected: event_res=%0d", event_res);
				mismatches++;
			end else begin
				want = events_due.pop_front();
				if (event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, event_res);
					mismatches++;
				end
				if (command_id !== want.command_id) begin
					$error("command_id: expected %0h, got %0h", want.command_id, command_id);
					mismatches++;
				end
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %0h, got %0h", want.payload_byte,
						payload_byte);
					mismatches++;
				end
				if (payload_index !== want.payload_index) begin
					$error("payload_index: expected %0d, got %0d", want.payload_index,
						payload_index);
					mismatches++;
				end
				if (frame_length !== want.frame_length) begin
					$error("frame_length: expected %0d, got %0d", want.frame_length,
						frame_length);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		result_t r;
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		r = advance_frame(b);
		events_due.push_back(r);
		if (r.event_res != EV_IGNORED)
			frame_items++;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
			input logic [7:0] body[$], input bit corrupt);
		logic [7:0] sum;
		send_byte(start_value);
		send_byte(len);
		if (len == 8'd0)
			return;
		send_byte(cmd);
		sum = len ^ cmd;
		foreach (body[i]) begin
			send_byte(body[i]);
			sum = sum ^ body[i];
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_byte(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= START_BYTE_ADDR;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		start_value = v;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== v) begin
			$error("start_byte readback: expected %0h, got %0h", v, prdata[7:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_traffic(input int target);
		int goal;
		int pick;
		int len;
		logic [7:0] body[$];
		goal = frame_items + target;
		while (frame_items < goal) begin
			pick = $urandom_range(99);
			body.delete();
			if (pick < 70) begin
				len = ($urandom_range(99) == 0) ? $urandom_range(100, 255)
					: $urandom_range(1, 8);
				repeat (len - 1) body.push_back(8'($urandom_range(255)));
				send_frame(8'(len), 8'($urandom_range(255)), body,
					$urandom_range(9) == 0);
			end else if (pick < 80) begin
				send_frame(8'd0, 8'd0, body, 1'b0);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
			end else begin
				len = $urandom_range(3, 8);
				send_byte(start_value);
				send_byte(8'(len));
				send_byte(8'($urandom_range(255)));
				repeat ($urandom_range(0, len - 3)) send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_directed();
		logic [7:0] body[$];
		write_start_byte(8'hA5);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'd0, 8'd0, body, 1'b0);
		send_frame(8'd1, 8'hFF, body, 1'b0);
		send_frame(8'd1, 8'h00, body, 1'b1);
		body = '{8'hA5, 8'hFF};
		send_frame(8'd3, 8'hA5, body, 1'b0);
		body = '{8'h80};
		send_frame(8'd2, 8'h7E, body, 1'b1);
		settle();
	endtask

	task automatic test_max_length();
		logic [7:0] body[$];
		repeat (254) body.push_back(8'($urandom_range(255)));
		send_frame(8'd255, 8'($urandom_range(255)), body, 1'b0);
		settle();
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_left = 300;
		@(posedge clk);
		run_traffic(40);
		settle();
	endtask

	task automatic test_idle_phases();
		write_start_byte(8'h00);
		run_traffic(300);
		settle();
		idle_pct = 46;
		write_start_byte(8'hFF);
		run_traffic(300);
		settle();
		idle_pct = 0;
		stall_pct = 46;
		write_start_byte(8'($urandom_range(255)));
		run_traffic(300);
		settle();
		idle_pct = 26;
		stall_pct = 26;
		write_start_byte(8'($urandom_range(255)));
		run_traffic(300);
		settle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		start_value = 8'd0;
		frame_phase = PH_HUNT;
		held_length = 8'd0;
		held_command = 8'd0;
		next_index = 8'd0;
		check_acc = 8'd0;
		mismatches = 0;
		frame_items = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_max_length();
		test_backpressure();
		test_idle_phases();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
rtl/cfp_pkg.sv
rtl/command_frame_parser_core.sv
rtl/cfp_checker.sv
dv/tb.sv
